// ----- rtl/core/fcl_pkg.sv -----
// fcl_pkg: constants, packet descriptor type and mod-255 helper for the
// framed command link handler; no dependencies
package fcl_pkg;

  localparam int PACKET_LEN = 8;
  localparam int REPLY_LEN  = 7;

  localparam logic [7:0] FRAME_BEGIN = 8'd255;
  localparam logic [7:0] FRAME_END   = 8'd175;
  localparam logic [7:0] OP_START    = 8'd101;
  localparam logic [7:0] OP_STOP     = 8'd114;
  localparam logic [7:0] OP_SYN      = 8'd238;
  localparam logic [7:0] OP_ACK      = 8'd174;
  localparam logic [7:0] OP_ERR      = 8'd221;
  localparam logic [7:0] ERR_CMD     = 8'd105;
  localparam logic [7:0] ERR_ZONE    = 8'd111;
  localparam logic [7:0] ERR_TIME    = 8'd112;

  localparam logic [1:0] ZCMD_NONE  = 2'd0;
  localparam logic [1:0] ZCMD_START = 2'd1;
  localparam logic [1:0] ZCMD_STOP  = 2'd2;

  localparam logic REG_MAX_ZONE    = 1'b0;
  localparam logic REG_MAX_MINUTES = 1'b1;

  typedef logic [$clog2(PACKET_LEN)-1:0] pos_t;
  typedef logic [$clog2(REPLY_LEN)-1:0]  rpos_t;

  // one checked packet, as handed from the front to the back
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  op;
    logic [7:0]  zone;
    logic [7:0]  minutes;
    logic [15:0] chk;
  } pkt_t;

  // acc is always below 255
  function automatic logic [7:0] add_mod255(logic [7:0] acc, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

// ----- rtl/core/fcl_rx_if.sv -----
// fcl_rx_if: receive byte channel (valid/ready plus payload)
// no dependencies
interface fcl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, rx_byte, timeout, input ready);
  modport sink (input valid, rx_byte, timeout, output ready);
endinterface

// ----- rtl/core/fcl_tx_if.sv -----
// fcl_tx_if: reply byte channel (valid/ready plus payload)
// no dependencies
interface fcl_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [1:0] zone_cmd;
  logic [7:0] zone;
  logic [7:0] minutes;

  modport source (output valid, tx_byte, last_byte, zone_cmd, zone, minutes, input ready);
  modport sink (input valid, tx_byte, last_byte, zone_cmd, zone, minutes, output ready);
endinterface

// ----- rtl/core/fcl_front.sv -----
// fcl_front: assembles received bytes into packets, checks framing and
// fletcher-16 on the fly; depends on fcl_pkg and fcl_rx_if
module fcl_front (
  input  logic          clk,
  input  logic          rst,
  fcl_rx_if.sink        rx,
  output fcl_pkg::pkt_t pkt,
  output logic          pkt_push,
  input  logic          pkt_full
);
  import fcl_pkg::*;

  pos_t       count;
  logic [7:0] s1, s2, p1, p2;
  logic       head_ok, chk_ok;
  logic [7:0] id, op, zone, minutes, b5;

  logic       accept;
  logic [7:0] s1_next, s2_next, p1_next, p2_next;
  logic       at_end;

  assign rx.ready = !pkt_full;
  assign accept   = rx.valid && rx.ready;
  assign at_end   = (count == pos_t'(PACKET_LEN - 1));

  always_comb begin
    s1_next = add_mod255((count == '0) ? 8'd0 : s1, rx.rx_byte);
    s2_next = add_mod255((count == '0) ? 8'd0 : s2, s1_next);
    // partial sum covers bytes 1..4
    p1_next = add_mod255((count == pos_t'(1)) ? 8'd0 : p1, rx.rx_byte);
    p2_next = add_mod255((count == pos_t'(1)) ? 8'd0 : p2, p1_next);
  end

  assign pkt_push = accept && !rx.timeout && at_end && head_ok && chk_ok &&
                    (rx.rx_byte == FRAME_END);
  assign pkt = '{id: id, op: op, zone: zone, minutes: minutes, chk: {s2_next, s1_next}};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (rx.timeout) begin
        count <= '0;
      end else begin
        count <= at_end ? '0 : count + pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !rx.timeout) begin
      s1 <= s1_next;
      s2 <= s2_next;
      if (count >= pos_t'(1) && count <= pos_t'(4)) begin
        p1 <= p1_next;
        p2 <= p2_next;
      end
      case (count)
        pos_t'(0): head_ok <= (rx.rx_byte == FRAME_BEGIN);
        pos_t'(1): id      <= rx.rx_byte;
        pos_t'(2): op      <= rx.rx_byte;
        pos_t'(3): zone    <= rx.rx_byte;
        pos_t'(4): minutes <= rx.rx_byte;
        pos_t'(5): b5      <= rx.rx_byte;
        // received check: byte 5 high, byte 6 low
        pos_t'(6): chk_ok  <= (p2 == b5) && (p1 == rx.rx_byte);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/fcl_queue.sv -----
// fcl_queue: two-entry packet queue between front and back
// depends on fcl_pkg
module fcl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fcl_pkg::pkt_t push_data,
  output logic          full,
  output logic          not_empty,
  output fcl_pkg::pkt_t head,
  input  logic          pop
);
  import fcl_pkg::*;

  pkt_t       entries [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/fcl_back.sv -----
// fcl_back: session handling, command checks and reply sequencer
// depends on fcl_pkg and fcl_tx_if
module fcl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pkt_valid,
  input  fcl_pkg::pkt_t pkt,
  output logic          pkt_pop,
  input  logic [7:0]    max_zone,
  input  logic [7:0]    max_minutes,
  fcl_tx_if.source      tx
);
  import fcl_pkg::*;

  logic       busy;
  rpos_t      pos;
  logic [7:0] session_id;
  logic       session_open;
  logic [7:0] r_id, r_c1, r_c2;
  logic [15:0] r_chk;
  logic [1:0] r_cmd;
  logic [7:0] r_zone, r_min;
  logic       tx_valid;

  logic       emit, id_match, zone_ok, time_ok, advance;
  logic       session_open_next;
  logic [7:0] session_id_next, c1, c2, zone_v, min_v;
  logic [1:0] cmd;
  logic [7:0] beat_byte;

  assign pkt_pop  = pkt_valid && !busy;
  assign id_match = (pkt.id == session_id);
  assign zone_ok  = (pkt.zone != 8'd0) && (pkt.zone <= max_zone);
  assign time_ok  = (pkt.minutes != 8'd0) && (pkt.minutes <= max_minutes);
  assign advance  = busy && (!tx_valid || tx.ready);

  always_comb begin
    emit              = 1'b0;
    session_id_next   = session_id;
    session_open_next = session_open;
    c1     = OP_ERR;
    c2     = ERR_CMD;
    cmd    = ZCMD_NONE;
    zone_v = 8'd0;
    min_v  = 8'd0;
    if (pkt.op == OP_SYN) begin
      emit              = 1'b1;
      session_id_next   = pkt.id;
      session_open_next = 1'b0;
      c1 = OP_SYN;
      c2 = OP_ACK;
    end else if (pkt.op == OP_ACK && id_match && !session_open) begin
      session_open_next = 1'b1;
    end else if (session_open && id_match) begin
      emit = 1'b1;
      if (pkt.op == OP_START) begin
        if (!zone_ok) begin
          c2 = ERR_ZONE;
        end else if (!time_ok) begin
          c2 = ERR_TIME;
        end else begin
          c1     = OP_ACK;
          c2     = 8'd0;
          cmd    = ZCMD_START;
          zone_v = pkt.zone;
          min_v  = pkt.minutes;
        end
      end else if (pkt.op == OP_STOP) begin
        if (!zone_ok) begin
          c2 = ERR_ZONE;
        end else begin
          c1     = OP_ACK;
          c2     = 8'd0;
          cmd    = ZCMD_STOP;
          zone_v = pkt.zone;
        end
      end
    end
  end

  always_comb begin
    case (pos)
      rpos_t'(0): beat_byte = FRAME_BEGIN;
      rpos_t'(1): beat_byte = r_id;
      rpos_t'(2): beat_byte = r_c1;
      rpos_t'(3): beat_byte = r_c2;
      rpos_t'(4): beat_byte = r_chk[7:0];
      rpos_t'(5): beat_byte = r_chk[15:8];
      default:    beat_byte = FRAME_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pos          <= '0;
      session_id   <= 8'd0;
      session_open <= 1'b0;
      tx_valid     <= 1'b0;
    end else begin
      if (pkt_pop) begin
        session_id   <= session_id_next;
        session_open <= session_open_next;
        busy         <= emit;
        pos          <= '0;
      end else if (advance) begin
        pos <= pos + rpos_t'(1);
        if (pos == rpos_t'(REPLY_LEN - 1)) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        tx_valid <= 1'b1;
      end else if (tx.ready) begin
        tx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_pop) begin
      // in every replying case the packet id equals the session id (after a SYN, the new one)
      r_id   <= pkt.id;
      r_c1   <= c1;
      r_c2   <= c2;
      r_chk  <= pkt.chk;
      r_cmd  <= cmd;
      r_zone <= zone_v;
      r_min  <= min_v;
    end
    if (advance) begin
      tx.tx_byte   <= beat_byte;
      tx.last_byte <= (pos == rpos_t'(REPLY_LEN - 1));
      tx.zone_cmd  <= r_cmd;
      tx.zone      <= r_zone;
      tx.minutes   <= r_min;
    end
  end

  assign tx.valid = tx_valid;

endmodule

// ----- rtl/core/framed_command_link_handler.sv -----
// framed_command_link_handler: top level with apb register port
// depends on fcl_pkg, fcl_rx_if, fcl_tx_if, fcl_front, fcl_queue, fcl_back
//
// Bytes on rx_ch are taken one per cycle while the queue has room and grouped into
// 8-byte packets; a beat with timeout set drops any partial packet. The front
// checks framing and the Fletcher-16 as bytes stream in, so a good packet reaches
// the two-entry queue in the cycle its last byte is taken. The back pops one
// packet at a time and sends a 7-beat reply on tx_ch at one beat per cycle when
// tx_ch is ready, through a registered output stage; a packet with no reply leaves
// the back idle. Input stalls only when both queue entries are full, so sustained
// throughput is one byte per cycle as long as tx_ch drains at least 7 beats per 8
// input bytes. Registers: max_zone at address 0, max_minutes at address 4.
module framed_command_link_handler (
  input  logic        clk,
  input  logic        rst,
  fcl_rx_if.sink      rx_ch,
  fcl_tx_if.source    tx_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fcl_pkg::*;

  logic [7:0] max_zone, max_minutes;
  logic       reg_sel;
  pkt_t       front_pkt, head_pkt;
  logic       front_push, q_full, q_not_empty, q_pop;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign prdata  = (reg_sel == REG_MAX_MINUTES) ? {24'd0, max_minutes} : {24'd0, max_zone};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_zone    <= 8'd8;
      max_minutes <= 8'd60;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == REG_MAX_ZONE) begin
        max_zone <= pwdata[7:0];
      end else begin
        max_minutes <= pwdata[7:0];
      end
    end
  end

  fcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .pkt      (front_pkt),
    .pkt_push (front_push),
    .pkt_full (q_full)
  );

  fcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_pkt),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_pkt),
    .pop       (q_pop)
  );

  fcl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pkt_valid   (q_not_empty),
    .pkt         (head_pkt),
    .pkt_pop     (q_pop),
    .max_zone    (max_zone),
    .max_minutes (max_minutes),
    .tx          (tx_ch)
  );

endmodule
